// ===== sv/lfdc_pkg.sv =====
// Shared types, register indexes and constants for the line follower drive controller.
// Used by lfdc_step and line_follower_drive_controller_unit. No dependencies.
`timescale 1ns / 1ps

package lfdc_pkg;

   // Default width of the free-running PWM counter
   localparam int PWM_BITS_DEF = 8;

   // Register indexes on the csr port
   localparam logic [2:0] REG_CONTROL_MODE = 3'd0;
   localparam logic [2:0] REG_GAIN_P       = 3'd1;
   localparam logic [2:0] REG_GAIN_I       = 3'd2;
   localparam logic [2:0] REG_GAIN_D       = 3'd3;
   localparam logic [2:0] REG_BASE_DUTY    = 3'd4;
   localparam logic [2:0] REG_DEAD_BAND    = 3'd5;
   localparam logic [2:0] REG_SEARCH_DUTY  = 3'd6;
   localparam logic [2:0] REG_ERROR_SCALE  = 3'd7;

   // Item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Control modes
   localparam logic MODE_TABLE = 1'b0;
   localparam logic MODE_INCR  = 1'b1;

   // Duty limits and fixed turn duties
   localparam logic [7:0] DUTY_MAX  = 8'd250;
   localparam logic [7:0] DUTY_MIN  = 8'd30;
   localparam logic [7:0] TURN_FAST = 8'd220;
   localparam logic [7:0] TURN_SLOW = 8'd50;

   // Register reset values
   localparam logic [7:0] RST_GAIN_P      = 8'd60;
   localparam logic [7:0] RST_GAIN_I      = 8'd2;
   localparam logic [7:0] RST_GAIN_D      = 8'd15;
   localparam logic [7:0] RST_BASE_DUTY   = 8'd180;
   localparam logic [5:0] RST_DEAD_BAND   = 6'd3;
   localparam logic [7:0] RST_SEARCH_DUTY = 8'd120;
   localparam logic [5:0] RST_ERROR_SCALE = 6'd20;

   // Folded coefficients at reset: (p+i+d)*scale and p+2*d
   localparam logic [15:0] RST_KE_S = 16'((60 + 2 + 15) * 20);
   localparam logic [9:0]  RST_KP   = 10'(60 + 2 * 15);

   // One input item
   typedef struct packed {
      logic opcode;
      logic left_sensor_raw;
      logic right_sensor_raw;
   } req_type;

   // One result item
   typedef struct packed {
      logic       left_enable;
      logic       right_enable;
      logic [7:0] left_duty_out;
      logic [7:0] right_duty_out;
      logic       line_lost;
   } rsp_type;

   // Configuration as seen by the step logic (gains folded)
   typedef struct packed {
      logic        control_mode;
      logic [7:0]  base_duty;
      logic [5:0]  dead_band;
      logic [7:0]  search_duty;
      logic [5:0]  error_scale;
      logic [15:0] ke_s;   // (gain_p + gain_i + gain_d) * error_scale
      logic [9:0]  kp;     // gain_p + 2 * gain_d
   } cfg_type;

   // Steering state carried from item to item
   typedef struct packed {
      logic [7:0]        left_duty;
      logic [7:0]        right_duty;
      logic signed [7:0] prev_error;
      logic              lost;
   } state_type;

   // Clamp a signed duty sum into DUTY_MIN..DUTY_MAX
   function automatic logic [7:0] clamp_duty(input logic signed [20:0] v);
      logic [7:0] r;
      if (v > $signed({13'b0, DUTY_MAX})) begin
         r = DUTY_MAX;
      end else if (v < $signed({13'b0, DUTY_MIN})) begin
         r = DUTY_MIN;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/line_follower_drive_controller_unit.sv =====
// Top level of the line follower drive controller: csr registers, state, PWM, output register.
// Depends on lfdc_pkg and lfdc_step.
`timescale 1ns / 1ps

// Usage
//   req_* : one item per handshake, either a sensor sample (opcode 0) or a PWM tick
//           (opcode 1). Accepted when req_valid is high and req_stall is low.
//   rsp_* : exactly one result item per accepted item, in order: both PWM enables,
//           both duties and the line-lost flag as they stand after that item.
//   csr_* : write-only registers, written on any cycle with csr_we high; write
//           them only while no item is in flight.
// Result: registered on accept; it is in the output register the cycle after accept.
// Throughput: one item per cycle unless a held result is stalled. The whole step (one 11x8 multiply, add, clamp)
// sits between the state registers and the output register.
// Stall: req_stall follows rsp_stall while a result is held, so a new item goes in
// whenever the held result leaves in the same cycle.
// Reset: registers return to their defaults, both duties to 180, error history,
// PWM counter and line-lost flag to zero; no result is pending.

module line_follower_drive_controller_unit #(
   parameter int PWM_BITS = lfdc_pkg::PWM_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // Input items
   input  logic              req_valid,
   output logic              req_stall,
   input  lfdc_pkg::req_type req_data,
   // Result items
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lfdc_pkg::rsp_type rsp_data,
   // Registers
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   localparam int CMP_W = (PWM_BITS > 8) ? PWM_BITS : 8;

   logic                control_mode_ff, control_mode_in;
   logic [7:0]          gain_p_ff, gain_p_in;
   logic [7:0]          gain_i_ff, gain_i_in;
   logic [7:0]          gain_d_ff, gain_d_in;
   logic [7:0]          base_duty_ff, base_duty_in;
   logic [5:0]          dead_band_ff, dead_band_in;
   logic [7:0]          search_duty_ff, search_duty_in;
   logic [5:0]          error_scale_ff, error_scale_in;
   logic [15:0]         ke_s_ff, ke_s_in;
   logic [9:0]          kp_ff, kp_in;
   logic [9:0]          ke_sum;

   lfdc_pkg::cfg_type   cfg;
   lfdc_pkg::state_type state_ff, state_in, step_nxt;
   logic [PWM_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lfdc_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                req_accept;

   // Register write decode
   always_comb begin
      control_mode_in = control_mode_ff;
      gain_p_in       = gain_p_ff;
      gain_i_in       = gain_i_ff;
      gain_d_in       = gain_d_ff;
      base_duty_in    = base_duty_ff;
      dead_band_in    = dead_band_ff;
      search_duty_in  = search_duty_ff;
      error_scale_in  = error_scale_ff;
      if (csr_we) begin
         unique case (csr_index)
            lfdc_pkg::REG_CONTROL_MODE: control_mode_in = csr_wdata[0];
            lfdc_pkg::REG_GAIN_P:       gain_p_in       = csr_wdata;
            lfdc_pkg::REG_GAIN_I:       gain_i_in       = csr_wdata;
            lfdc_pkg::REG_GAIN_D:       gain_d_in       = csr_wdata;
            lfdc_pkg::REG_BASE_DUTY:    base_duty_in    = csr_wdata;
            lfdc_pkg::REG_DEAD_BAND:    dead_band_in    = csr_wdata[5:0];
            lfdc_pkg::REG_SEARCH_DUTY:  search_duty_in  = csr_wdata;
            lfdc_pkg::REG_ERROR_SCALE:  error_scale_in  = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Gains are folded at write time so the item path keeps a single multiply
   assign ke_sum  = {2'b0, gain_p_in} + {2'b0, gain_i_in} + {2'b0, gain_d_in};
   assign kp_in   = {2'b0, gain_p_in} + {1'b0, gain_d_in, 1'b0};
   assign ke_s_in = {6'b0, ke_sum} * {10'b0, error_scale_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         control_mode_ff <= lfdc_pkg::MODE_INCR;
         gain_p_ff       <= lfdc_pkg::RST_GAIN_P;
         gain_i_ff       <= lfdc_pkg::RST_GAIN_I;
         gain_d_ff       <= lfdc_pkg::RST_GAIN_D;
         base_duty_ff    <= lfdc_pkg::RST_BASE_DUTY;
         dead_band_ff    <= lfdc_pkg::RST_DEAD_BAND;
         search_duty_ff  <= lfdc_pkg::RST_SEARCH_DUTY;
         error_scale_ff  <= lfdc_pkg::RST_ERROR_SCALE;
         ke_s_ff         <= lfdc_pkg::RST_KE_S;
         kp_ff           <= lfdc_pkg::RST_KP;
      end else begin
         control_mode_ff <= control_mode_in;
         gain_p_ff       <= gain_p_in;
         gain_i_ff       <= gain_i_in;
         gain_d_ff       <= gain_d_in;
         base_duty_ff    <= base_duty_in;
         dead_band_ff    <= dead_band_in;
         search_duty_ff  <= search_duty_in;
         error_scale_ff  <= error_scale_in;
         if (csr_we) begin
            ke_s_ff <= ke_s_in;
            kp_ff   <= kp_in;
         end
      end
   end

   assign cfg.control_mode = control_mode_ff;
   assign cfg.base_duty    = base_duty_ff;
   assign cfg.dead_band    = dead_band_ff;
   assign cfg.search_duty  = search_duty_ff;
   assign cfg.error_scale  = error_scale_ff;
   assign cfg.ke_s         = ke_s_ff;
   assign cfg.kp           = kp_ff;

   // Handshake: take an item whenever the output register is free or draining
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   lfdc_step u_step (
      .req (req_data),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (step_nxt)
   );

   // State and PWM counter advance on accept
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (req_accept) begin
         state_in = step_nxt;
         if (req_data.opcode == lfdc_pkg::OP_TICK) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // Result from the post-item state
   always_comb begin
      rsp_data_in.left_enable    = CMP_W'(cnt_in) < CMP_W'(state_in.left_duty);
      rsp_data_in.right_enable   = CMP_W'(cnt_in) < CMP_W'(state_in.right_duty);
      rsp_data_in.left_duty_out  = state_in.left_duty;
      rsp_data_in.right_duty_out = state_in.right_duty;
      rsp_data_in.line_lost      = state_in.lost;
   end

   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.left_duty  <= lfdc_pkg::RST_BASE_DUTY;
         state_ff.right_duty <= lfdc_pkg::RST_BASE_DUTY;
         state_ff.prev_error <= '0;
         state_ff.lost       <= 1'b0;
         cnt_ff              <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept))
      else $error("result appeared without an accepted item");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.left_duty_out == state_ff.left_duty &&
                        rsp_data_ff.right_duty_out == state_ff.right_duty &&
                        rsp_data_ff.line_lost == state_ff.lost))
      else $error("held result disagrees with steering state");

   a_tick_keeps_duty: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.opcode == lfdc_pkg::OP_TICK) |=>
         ($stable(state_ff.left_duty) && $stable(state_ff.right_duty)))
      else $error("PWM tick changed a duty");

   a_pid_clamped: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.opcode == lfdc_pkg::OP_SAMPLE &&
       control_mode_ff == lfdc_pkg::MODE_INCR && !step_nxt.lost) |=>
         (state_ff.left_duty >= lfdc_pkg::DUTY_MIN &&
          state_ff.left_duty <= lfdc_pkg::DUTY_MAX &&
          state_ff.right_duty >= lfdc_pkg::DUTY_MIN &&
          state_ff.right_duty <= lfdc_pkg::DUTY_MAX))
      else $error("PID duty outside clamp range");

endmodule

// ===== sv/lfdc_step.sv =====
// Next-state logic for one item: sensor decode, incremental PID or turn table, clamp.
// Depends on lfdc_pkg.
`timescale 1ns / 1ps

module lfdc_step (
   input  lfdc_pkg::req_type   req,
   input  lfdc_pkg::cfg_type   cfg,
   input  lfdc_pkg::state_type cur,
   output lfdc_pkg::state_type nxt
);

   logic                sl, sr, on_left, on_right, lost;
   logic                zero_err;
   logic signed [7:0]   err;
   logic signed [19:0]  kee;
   logic signed [18:0]  kpp;
   logic signed [19:0]  delta;
   logic signed [19:0]  delta_adj;
   logic signed [19:0]  q;
   logic signed [20:0]  base_ext;
   logic signed [20:0]  lsum, rsum;
   logic signed [19:0]  kes_ext;

   // Active-low sensors: only-left means drifting right of line, and so on
   assign sl       = ~req.left_sensor_raw;
   assign sr       = ~req.right_sensor_raw;
   assign on_left  = sl & ~sr;
   assign on_right = sr & ~sl;
   assign lost     = ~sl & ~sr;

   // Error after dead band; zero when centered
   always_comb begin
      zero_err = 1'b1;
      err      = '0;
      if (on_left) begin
         zero_err = (cfg.error_scale <= cfg.dead_band);
         err      = -$signed({2'b00, cfg.error_scale});
      end else if (on_right) begin
         zero_err = (cfg.error_scale <= cfg.dead_band);
         err      = $signed({2'b00, cfg.error_scale});
      end else if (lost) begin
         zero_err = ({cfg.error_scale, 1'b0} <= {1'b0, cfg.dead_band});
         err      = $signed({1'b0, cfg.error_scale, 1'b0});
      end
      if (zero_err) begin
         err = '0;
      end
   end

   // delta = (p+i+d)*e - (p+2d)*prev; the e term comes from the folded product
   assign kes_ext = $signed({4'b0, cfg.ke_s});

   always_comb begin
      kee = '0;
      if (!zero_err) begin
         if (on_left) begin
            kee = -kes_ext;
         end else if (on_right) begin
            kee = kes_ext;
         end else if (lost) begin
            kee = $signed({3'b0, cfg.ke_s, 1'b0});
         end
      end
   end

   assign kpp       = $signed({1'b0, cfg.kp}) * cur.prev_error;
   assign delta     = kee - {kpp[18], kpp};
   // divide by 4, truncating toward zero
   assign delta_adj = delta + (delta[19] ? 20'sd3 : 20'sd0);
   assign q         = delta_adj >>> 2;

   assign base_ext = $signed({13'b0, cfg.base_duty});
   assign lsum     = base_ext + {q[19], q};
   assign rsum     = base_ext - {q[19], q};

   // Select next state
   always_comb begin
      nxt = cur;
      if (req.opcode == lfdc_pkg::OP_SAMPLE) begin
         nxt.lost = lost;
         if (cfg.control_mode == lfdc_pkg::MODE_INCR) begin
            nxt.prev_error = err;
            nxt.left_duty  = lfdc_pkg::clamp_duty(lsum);
            nxt.right_duty = lfdc_pkg::clamp_duty(rsum);
         end else if (on_left) begin
            nxt.left_duty  = lfdc_pkg::TURN_SLOW;
            nxt.right_duty = lfdc_pkg::TURN_FAST;
         end else if (on_right) begin
            nxt.left_duty  = lfdc_pkg::TURN_FAST;
            nxt.right_duty = lfdc_pkg::TURN_SLOW;
         end else begin
            nxt.left_duty  = cfg.base_duty;
            nxt.right_duty = cfg.base_duty;
         end
         if (lost) begin
            nxt.left_duty  = cfg.search_duty;
            nxt.right_duty = cfg.search_duty;
         end
      end
   end

endmodule
